@@ rtl/hpmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_pkg: shared types and constants of the half-pel predictor
// Row geometry, mode bit positions and the item that the front part hands to
// the back part through the queue.
// ----------------------------------------------------------------------------
package hpmc_pkg;

    localparam int MAX_ROW_PIXELS = 16;
    localparam int ROW_BYTES      = MAX_ROW_PIXELS + 1;
    localparam int NARROW_PIXELS  = 8;

    // Bit positions inside the mode field.
    localparam int MODE_BIT_HX  = 0;
    localparam int MODE_BIT_HY  = 1;
    localparam int MODE_BIT_AVG = 2;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ROW_BYTES-1:0][7:0]      t_row;
    typedef logic [MAX_ROW_PIXELS-1:0][7:0] t_pixels;

    typedef struct packed {
        logic [2:0] mode;
        logic       wide;
        t_row       cur;
        t_row       prev;
        t_pixels    dest;
    } t_work_item;

endpackage

@@ rtl/hpmc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_front: row intake and classification
// Assembles the current reference row, keeps the previous row and hands a
// work item to the queue unless the row only primes the vertical store.
// ----------------------------------------------------------------------------
module hpmc_front
    import hpmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_accept,
    input  logic [2:0]  i_mode,
    input  logic        i_wide,
    input  logic        i_first_row,
    input  logic [63:0] i_ref_low,
    input  logic [63:0] i_ref_high,
    input  logic [7:0]  i_ref_extra,
    input  logic [63:0] i_dest_low,
    input  logic [63:0] i_dest_high,
    output logic        o_push,
    output t_work_item  o_item
);

    t_row r_prev_row;
    t_row cur;

    always_comb begin
        for (int i = 0; i < NARROW_PIXELS; i++) begin
            cur[i] = i_ref_low[8*i +: 8];
        end
        for (int i = NARROW_PIXELS; i < MAX_ROW_PIXELS; i++) begin
            if (i_wide) begin
                cur[i] = i_ref_high[8*(i-NARROW_PIXELS) +: 8];
            end else if (i == NARROW_PIXELS) begin
                cur[i] = i_ref_extra;
            end else begin
                cur[i] = 8'h00;
            end
        end
        cur[MAX_ROW_PIXELS] = i_wide ? i_ref_extra : 8'h00;
    end

    // A narrow row rewrites entries 0..8 only; the rest keep older contents.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < ROW_BYTES; i++) begin
                if (i_wide || i <= NARROW_PIXELS) begin
                    r_prev_row[i] <= cur[i];
                end
            end
        end
    end

    assign o_push = i_accept && !(i_mode[MODE_BIT_HY] && i_first_row);

    always_comb begin
        o_item.mode = i_mode;
        o_item.wide = i_wide;
        o_item.cur  = cur;
        o_item.prev = r_prev_row;
        o_item.dest = {i_dest_high, i_dest_low};
    end

endmodule

@@ rtl/hpmc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_queue: short work queue
// Holds classified rows between the front and the back so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module hpmc_queue
    import hpmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_work_item i_item,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_work_item o_head
);

    t_work_item            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr;
    logic [QCNT_W-1:0]     r_count;
    logic [QPTR_W-1:0]     n_wr_ptr;
    logic [QPTR_W-1:0]     n_rd_ptr;
    logic [QCNT_W-1:0]     n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/hpmc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_back: interpolation and output register
// Forms the half-pel prediction of the queue head, optionally averages it
// with the destination row and holds the result until it is taken.
// ----------------------------------------------------------------------------
module hpmc_back
    import hpmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_work_item  i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_pred_low,
    output logic [63:0] o_pred_high
);

    logic        r_out_valid;
    logic [63:0] r_pred_low;
    logic [63:0] r_pred_high;
    t_pixels     pred;
    logic        hx;
    logic        hy;
    logic        avg;

    assign hx  = i_head.mode[MODE_BIT_HX];
    assign hy  = i_head.mode[MODE_BIT_HY];
    assign avg = i_head.mode[MODE_BIT_AVG];

    always_comb begin
        logic [9:0] sum4;
        logic [8:0] sum2;
        logic [7:0] p;
        logic [8:0] sumd;
        for (int i = 0; i < MAX_ROW_PIXELS; i++) begin
            sum4 = {2'b00, i_head.cur[i]} + {2'b00, i_head.cur[i+1]}
                 + {2'b00, i_head.prev[i]} + {2'b00, i_head.prev[i+1]} + 10'd2;
            if (hy) begin
                sum2 = {1'b0, i_head.cur[i]} + {1'b0, i_head.prev[i]} + 9'd1;
            end else begin
                sum2 = {1'b0, i_head.cur[i]} + {1'b0, i_head.cur[i+1]} + 9'd1;
            end
            if (hx && hy) begin
                p = sum4[9:2];
            end else if (hx || hy) begin
                p = sum2[8:1];
            end else begin
                p = i_head.cur[i];
            end
            sumd = {1'b0, i_head.dest[i]} + {1'b0, p} + 9'd1;
            if (avg) begin
                p = sumd[8:1];
            end
            if (!i_head.wide && i >= NARROW_PIXELS) begin
                p = 8'h00;
            end
            pred[i] = p;
        end
    end

    assign o_pop = !i_empty && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pred_low  <= pred[NARROW_PIXELS-1:0];
            r_pred_high <= pred[MAX_ROW_PIXELS-1:NARROW_PIXELS];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pred_low  = r_pred_low;
    assign o_pred_high = r_pred_high;

endmodule

@@ rtl/half_pel_motion_comp_predictor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_pel_motion_comp_predictor_core: half-pel motion compensation predictor
// Copy, half-pel x, y and xy prediction of 8 or 16 pixel rows, in put or
// average-with-destination form, one reference row per transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  input     i_in_valid / o_in_ready      i_mode, i_wide, i_first_row, i_ref_*, i_dest_*
//  output    o_out_valid / i_out_ready    o_pred_low, o_pred_high
//
//  One row per cycle sustained while results are taken; a result is registered
//  in the queue by the front and then in the output register by the back.
//  The first row of a y or xy block updates the row store and gives no result.
//  A two-entry queue decouples intake from output; intake stalls only when
//  the queue is full behind a held result.
//  Reset clears the queue and the output valid; the row store is not cleared.
//
module half_pel_motion_comp_predictor_core
    import hpmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic        i_wide,
    input  logic        i_first_row,
    input  logic [63:0] i_ref_low,
    input  logic [63:0] i_ref_high,
    input  logic [7:0]  i_ref_extra,
    input  logic [63:0] i_dest_low,
    input  logic [63:0] i_dest_high,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_pred_low,
    output logic [63:0] o_pred_high
);

    logic       accept;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_work_item item;
    t_work_item head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    hpmc_front u_front (
        .i_clk       (i_clk),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_wide      (i_wide),
        .i_first_row (i_first_row),
        .i_ref_low   (i_ref_low),
        .i_ref_high  (i_ref_high),
        .i_ref_extra (i_ref_extra),
        .i_dest_low  (i_dest_low),
        .i_dest_high (i_dest_high),
        .o_push      (push),
        .o_item      (item)
    );

    hpmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    hpmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pred_low  (o_pred_low),
        .o_pred_high (o_pred_high)
    );

endmodule

@@ rtl/hpmc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmc_checker: port-level checks of the predictor
// Tracks transactions that owe a result and checks output behavior against
// that count.
// ----------------------------------------------------------------------------
module hpmc_checker
    import hpmc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_mode,
    input logic        i_first_row,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_pred_low,
    input logic [63:0] o_pred_high
);

    logic [2:0] r_pending;
    logic       in_take;
    logic       out_take;

    // Rows that prime the vertical store owe no result.
    assign in_take  = i_in_valid && o_in_ready && !(i_mode[MODE_BIT_HY] && i_first_row);
    assign out_take = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {2'b00, in_take} - {2'b00, out_take};
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid set right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pred_low) && $stable(o_pred_high))
        else $error("stalled result changed or vanished");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 3'd0)
        else $error("result shown with no transaction owing one");

    a_stall_only_when_backed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_pending >= 3'd2)
        else $error("input stalled while the pipeline holds too few rows");

endmodule

bind half_pel_motion_comp_predictor_core hpmc_checker u_hpmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_mode      (i_mode),
    .i_first_row (i_first_row),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pred_low  (o_pred_low),
    .o_pred_high (o_pred_high)
);

@@ tb/tb_half_pel_motion_comp_predictor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_half_pel_motion_comp_predictor_core: self-checking bench for the predictor
// Feeds directed and random reference rows through the input channel,
// computes the expected predicted rows with an independent software model of
// the row store and the averaging, and checks every output transaction in
// order while both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_half_pel_motion_comp_predictor_core;
    import hpmc_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ROWS  = 650;
    localparam int CALM_TAIL    = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 200;

    typedef enum logic [2:0] {
        PUT_COPY, PUT_X, PUT_Y, PUT_XY, AVG_COPY, AVG_X, AVG_Y, AVG_XY
    } t_pred_mode;

    typedef struct {
        logic [2:0]  mode;
        logic        wide;
        logic        first_row;
        logic [63:0] ref_low;
        logic [63:0] ref_high;
        logic [7:0]  ref_extra;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
    } t_ref_row;

    typedef struct {
        logic [63:0] pred_low;
        logic [63:0] pred_high;
    } t_pred_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_mode;
    logic        i_wide;
    logic        i_first_row;
    logic [63:0] i_ref_low;
    logic [63:0] i_ref_high;
    logic [7:0]  i_ref_extra;
    logic [63:0] i_dest_low;
    logic [63:0] i_dest_high;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_pred_low;
    logic [63:0] o_pred_high;

    t_ref_row  pending_rows[$];
    t_pred_row expected_preds[$];
    t_ref_row  drive_row;
    t_pred_row next_pred;
    t_pred_row want_pred;

    // Shadow copy of the row store, and which entries stimulus has written.
    t_row                  row_store = '0;
    bit [ROW_BYTES-1:0]    gen_written = '0;

    int fail_count   = 0;
    int quiet_cycles = 0;
    int in_gap       = 0;
    int out_gap      = 0;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int rate_age     = 0;

    half_pel_motion_comp_predictor_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_wide      (i_wide),
        .i_first_row (i_first_row),
        .i_ref_low   (i_ref_low),
        .i_ref_high  (i_ref_high),
        .i_ref_extra (i_ref_extra),
        .i_dest_low  (i_dest_low),
        .i_dest_high (i_dest_high),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pred_low  (o_pred_low),
        .o_pred_high (o_pred_high)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int row_pixels(input logic wide);
        return wide ? MAX_ROW_PIXELS : NARROW_PIXELS;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Queues one row. A y-mode row that would read store entries never written
    // is turned into the first row of a new block instead.
    task automatic queue_row(input logic [2:0] mode, input logic wide,
                             input logic first_row, input logic [63:0] ref_low,
                             input logic [63:0] ref_high, input logic [7:0] ref_extra,
                             input logic [63:0] dest_low, input logic [63:0] dest_high);
        t_ref_row           row;
        int                 n;
        bit [ROW_BYTES-1:0] needed;
        n      = row_pixels(wide);
        needed = ROW_BYTES'((1 << (n + (mode[MODE_BIT_HX] ? 1 : 0))) - 1);
        if (mode[MODE_BIT_HY] && !first_row && ((needed & ~gen_written) != 0))
            first_row = 1'b1;
        gen_written |= ROW_BYTES'((1 << (n + 1)) - 1);
        row.mode      = mode;
        row.wide      = wide;
        row.first_row = first_row;
        row.ref_low   = ref_low;
        row.ref_high  = ref_high;
        row.ref_extra = ref_extra;
        row.dest_low  = dest_low;
        row.dest_high = dest_high;
        pending_rows.push_back(row);
    endtask

    // Updates the shadow store with one row and returns 1 when the row gives a
    // predicted row.
    function automatic bit predict_row(input t_ref_row row, output t_pred_row pred);
        t_row         cur;
        logic [127:0] refs;
        logic [127:0] dests;
        logic [127:0] out_px;
        int           n;
        int           p;
        bit           hx;
        bit           hy;
        n      = row_pixels(row.wide);
        hx     = row.mode[MODE_BIT_HX];
        hy     = row.mode[MODE_BIT_HY];
        refs   = {row.ref_high, row.ref_low};
        dests  = {row.dest_high, row.dest_low};
        out_px = '0;
        cur    = '0;
        pred   = '{default: '0};
        for (int i = 0; i < n; i++)
            cur[i] = refs[8*i +: 8];
        cur[n] = row.ref_extra;

        if (!(hy && row.first_row)) begin
            for (int i = 0; i < n; i++) begin
                if (hx && hy)
                    p = (int'(row_store[i]) + int'(row_store[i+1]) + int'(cur[i])
                         + int'(cur[i+1]) + 2) >> 2;
                else if (hy)
                    p = (int'(row_store[i]) + int'(cur[i]) + 1) >> 1;
                else if (hx)
                    p = (int'(cur[i]) + int'(cur[i+1]) + 1) >> 1;
                else
                    p = int'(cur[i]);
                if (row.mode[MODE_BIT_AVG])
                    p = (int'(dests[8*i +: 8]) + p + 1) >> 1;
                out_px[8*i +: 8] = p[7:0];
            end
            pred.pred_low  = out_px[63:0];
            pred.pred_high = out_px[127:64];
        end

        // Entries above the extra pixel keep what an earlier, wider row left.
        for (int i = 0; i <= n; i++)
            row_store[i] = cur[i];
        return !(hy && row.first_row);
    endfunction

    // Idle rates are redrawn as rate_age advances, so that busy and quiet stretches mix.
    always @(posedge i_clk) begin
        rate_age <= rate_age + 1;
        if (rate_age % 64 == 0) begin
            in_idle_pct  <= $urandom_range(0, 2) * 20;
            out_idle_pct <= $urandom_range(0, 2) * 20;
        end
    end

    // Input driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                if (predict_row(drive_row, next_pred))
                    expected_preds.push_back(next_pred);
            end
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_rows.size() > CALM_TAIL
                         && $urandom_range(0, 99) < in_idle_pct) begin
                in_gap = $urandom_range(0, 14);
                i_in_valid <= 1'b0;
            end else if (pending_rows.size() != 0) begin
                drive_row = pending_rows.pop_front();
                i_in_valid  <= 1'b1;
                i_mode      <= drive_row.mode;
                i_wide      <= drive_row.wide;
                i_first_row <= drive_row.first_row;
                i_ref_low   <= drive_row.ref_low;
                i_ref_high  <= drive_row.ref_high;
                i_ref_extra <= drive_row.ref_extra;
                i_dest_low  <= drive_row.dest_low;
                i_dest_high <= drive_row.dest_high;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (pending_rows.size() > CALM_TAIL
                     && $urandom_range(0, 99) < out_idle_pct) begin
            out_gap = $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_preds.size() == 0) begin
                report_mismatch("unexpected transaction, pred_low", o_pred_low, '0);
            end else begin
                want_pred = expected_preds.pop_front();
                if (o_pred_low !== want_pred.pred_low)
                    report_mismatch("pred_low", o_pred_low, want_pred.pred_low);
                if (o_pred_high !== want_pred.pred_high)
                    report_mismatch("pred_high", o_pred_high, want_pred.pred_high);
            end
        end
    end

    // Watchdog: count cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [2:0] blk_mode;
        logic       blk_wide;
        int         blk_rows;
        int         stop_at;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_mode      = '0;
        i_wide      = 1'b0;
        i_first_row = 1'b0;
        i_ref_low   = '0;
        i_ref_high  = '0;
        i_ref_extra = '0;
        i_dest_low  = '0;
        i_dest_high = '0;

        // Directed rows: field extremes, every mode, first rows with and
        // without effect, a narrow row with ignored high pixels, and width
        // changes between rows of the store.
        queue_row(PUT_COPY, 1'b0, 1'b1, '0, '0, 8'h00, '0, '0);
        queue_row(PUT_COPY, 1'b0, 1'b0, '1, '1, 8'hff, '1, '1);
        queue_row(PUT_COPY, 1'b1, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210,
                  8'h5a, '0, '0);
        queue_row(PUT_X, 1'b0, 1'b0, '1, '0, 8'h00, '0, '0);
        queue_row(PUT_X, 1'b1, 1'b1, 64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00,
                  8'hff, '0, '0);
        queue_row(PUT_Y, 1'b1, 1'b1, '1, '1, 8'hff, '0, '0);
        queue_row(PUT_Y, 1'b1, 1'b0, '0, '0, 8'h00, '0, '0);
        queue_row(PUT_XY, 1'b1, 1'b0, '1, '0, 8'h01, '0, '0);
        queue_row(PUT_XY, 1'b1, 1'b0, '0, '0, 8'h00, '1, '1);
        queue_row(AVG_COPY, 1'b1, 1'b0, '1, '1, 8'hff, '0, '0);
        queue_row(AVG_X, 1'b0, 1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210,
                  8'h80, '1, '1);
        queue_row(AVG_Y, 1'b0, 1'b1, 64'hfedcba9876543210, '0, 8'h11, '0, '0);
        queue_row(AVG_Y, 1'b0, 1'b0, 64'h0123456789abcdef, '0, 8'h22, '1, '0);
        queue_row(AVG_XY, 1'b0, 1'b0, '1, '0, 8'hff, '1, '0);
        queue_row(AVG_XY, 1'b1, 1'b1, '0, '0, 8'h00, '0, '0);
        queue_row(AVG_XY, 1'b1, 1'b0, '1, '1, 8'hff, '0, '0);
        queue_row(PUT_Y, 1'b1, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210,
                  8'hc3, '0, '0);
        queue_row(PUT_COPY, 1'b0, 1'b0, 64'hfedcba9876543210, '1, 8'h3c, '0, '0);
        queue_row(PUT_XY, 1'b1, 1'b0, '1, 64'h0123456789abcdef, 8'h7e, '0, '0);
        queue_row(AVG_Y, 1'b0, 1'b0, '0, '1, 8'h00, '1, '1);

        // Random part: mostly whole blocks of one shape, the rest loose rows.
        stop_at = pending_rows.size() + RANDOM_ROWS;
        while (pending_rows.size() < stop_at) begin
            if ($urandom_range(0, 3) != 0) begin
                blk_mode = 3'($urandom_range(0, 7));
                blk_wide = 1'($urandom_range(0, 1));
                blk_rows = $urandom_range(2, 9);
                for (int r = 0; r < blk_rows; r++)
                    queue_row(blk_mode, blk_wide, r == 0, rand_word(), rand_word(),
                              8'($urandom_range(0, 255)), rand_word(), rand_word());
            end else begin
                queue_row(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)),
                          rand_word(), rand_word(), 8'($urandom_range(0, 255)),
                          rand_word(), rand_word());
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_rows.size() == 0 && !i_in_valid && expected_preds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_preds.size() != 0)
            report_mismatch("predicted rows never delivered",
                            64'(expected_preds.size()), '0);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ half_pel_motion_comp_predictor_core.f @@
rtl/hpmc_pkg.sv
rtl/hpmc_front.sv
rtl/hpmc_queue.sv
rtl/hpmc_back.sv
rtl/half_pel_motion_comp_predictor_core.sv
rtl/hpmc_checker.sv
tb/tb_half_pel_motion_comp_predictor_core.sv
